@@ hw/rtl/mpsq_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the matrix power unit
// no dependencies

package mpsq_pkg;

  localparam int MAX_DIM_DEF = 8;
  localparam int ELEM_W      = 32;
  localparam int SIZE_W      = 4;
  localparam int EXP_W       = 31;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT    = 2'd1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd1;
  localparam logic [EXP_W-1:0]  EXP_RESET  = 31'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_DECIDE,
    S_PREP,
    S_ROW,
    S_MAC,
    S_WB,
    S_OPREP,
    S_OROW,
    S_OSHIFT
  } state_t;

  typedef struct packed {
    logic load_en;
    logic prod_ident;
    logic aop_from_p;
    logic aop_from_b;
    logic row_load;
    logic row_shift;
    logic acc_clr;
    logic mac_en;
    logic aop_rot;
    logic prod_wr;
    logic base_wr;
  } cell_ctl_t;

endpackage

@@ hw/rtl/matrix_power_by_squaring_unit.sv @@
`timescale 1ns / 1ps
// sequence: n*n input transfers to load, an init state, then per matrix product a decide
// state, prep, and per row a row tap load and n mac steps, then write-back; one or two
// products per exponent bit, a final decide, then output prep and per row a tap load and n shifts
// throughput: one matrix at a time, the single mac per column cell sets the product time
// reset: rst_n synchronous active low, clears control and sets size and exponent to one
// matrix power by square-and-multiply over a chain of column cells, depends on mpsq_pkg and mpsq_cell

module matrix_power_by_squaring_unit #(
  parameter int MAX_DIM = mpsq_pkg::MAX_DIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [mpsq_pkg::ELEM_W-1:0] in_element_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [mpsq_pkg::ELEM_W-1:0] out_element_out,
  output logic                             out_last_of_matrix,
  input  logic                             cfg_we,
  input  logic [mpsq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mpsq_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  // configuration
  logic [mpsq_pkg::SIZE_W-1:0] size_r;
  logic [mpsq_pkg::EXP_W-1:0]  exp_r;
  logic [mpsq_pkg::SIZE_W-1:0] eff_n;
  logic [IDX_W-1:0]            dim_m1;

  // sequencer
  mpsq_pkg::state_t state_r, state_nxt;
  logic [mpsq_pkg::EXP_W-1:0] rem_r;
  logic                       is_sq_r;
  logic [IDX_W-1:0]           r_cnt_r;
  logic [IDX_W-1:0]           t_cnt_r;
  logic [IDX_W-1:0]           load_row_r;
  logic [IDX_W-1:0]           load_col_r;
  mpsq_pkg::cell_ctl_t        ctl;

  // output register
  logic                        out_valid_r;
  logic [mpsq_pkg::ELEM_W-1:0] out_data_r;
  logic                        out_last_r;
  logic                        out_free;
  logic                        out_fill;

  logic in_xfer;
  logic load_done;
  logic t_end;
  logic r_end;

  logic [mpsq_pkg::ELEM_W-1:0] row_chain [MAX_DIM+1];
  logic [mpsq_pkg::ELEM_W-1:0] a_bcast;

  // size 0 counts as 1, oversize clamps to the chain length
  always_comb begin
    if (size_r == '0) begin
      eff_n = mpsq_pkg::SIZE_W'(1);
    end else if (size_r > mpsq_pkg::SIZE_W'(MAX_DIM)) begin
      eff_n = mpsq_pkg::SIZE_W'(MAX_DIM);
    end else begin
      eff_n = size_r;
    end
  end
  assign dim_m1 = IDX_W'(eff_n - mpsq_pkg::SIZE_W'(1));

  assign in_stall  = (state_r != mpsq_pkg::S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign load_done = (load_row_r == dim_m1) && (load_col_r == dim_m1);
  assign t_end     = (t_cnt_r == dim_m1);
  assign r_end     = (r_cnt_r == dim_m1);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_fill  = (state_r == mpsq_pkg::S_OSHIFT) && out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mpsq_pkg::S_IDLE: begin
        if (in_xfer && load_done) begin
          state_nxt = mpsq_pkg::S_INIT;
        end
      end
      mpsq_pkg::S_INIT:   state_nxt = mpsq_pkg::S_DECIDE;
      mpsq_pkg::S_DECIDE: begin
        if (rem_r == '0) begin
          state_nxt = mpsq_pkg::S_OPREP;
        end else if (rem_r[0]) begin
          state_nxt = mpsq_pkg::S_PREP;
        end else if ((rem_r >> 1) != '0) begin
          state_nxt = mpsq_pkg::S_PREP;
        end
      end
      mpsq_pkg::S_PREP: state_nxt = mpsq_pkg::S_ROW;
      mpsq_pkg::S_ROW:  state_nxt = mpsq_pkg::S_MAC;
      mpsq_pkg::S_MAC: begin
        if (t_end) begin
          state_nxt = r_end ? mpsq_pkg::S_WB : mpsq_pkg::S_ROW;
        end
      end
      mpsq_pkg::S_WB:    state_nxt = mpsq_pkg::S_DECIDE;
      mpsq_pkg::S_OPREP: state_nxt = mpsq_pkg::S_OROW;
      mpsq_pkg::S_OROW:  state_nxt = mpsq_pkg::S_OSHIFT;
      mpsq_pkg::S_OSHIFT: begin
        if (out_free && t_end) begin
          state_nxt = r_end ? mpsq_pkg::S_IDLE : mpsq_pkg::S_OROW;
        end
      end
      default: state_nxt = mpsq_pkg::S_IDLE;
    endcase
  end

  // cell controls
  always_comb begin
    ctl = '0;
    case (state_r)
      mpsq_pkg::S_IDLE:   ctl.load_en = in_xfer;
      mpsq_pkg::S_INIT:   ctl.prod_ident = 1'b1;
      mpsq_pkg::S_PREP: begin
        ctl.aop_from_p = !is_sq_r;
        ctl.aop_from_b = is_sq_r;
      end
      mpsq_pkg::S_ROW: begin
        ctl.row_load = 1'b1;
        ctl.acc_clr  = 1'b1;
      end
      mpsq_pkg::S_MAC: begin
        ctl.mac_en    = 1'b1;
        ctl.row_shift = 1'b1;
        // last step of a row: result enters the operand column tail
        ctl.aop_rot   = t_end;
      end
      mpsq_pkg::S_WB: begin
        ctl.prod_wr = !is_sq_r;
        ctl.base_wr = is_sq_r;
      end
      mpsq_pkg::S_OPREP: ctl.aop_from_p = 1'b1;
      mpsq_pkg::S_OROW: begin
        ctl.row_load = 1'b1;
        ctl.aop_rot  = 1'b1;
      end
      mpsq_pkg::S_OSHIFT: ctl.row_shift = out_free;
      default: ctl = '0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mpsq_pkg::S_IDLE;
      size_r      <= mpsq_pkg::SIZE_RESET;
      exp_r       <= mpsq_pkg::EXP_RESET;
      rem_r       <= '0;
      is_sq_r     <= 1'b0;
      r_cnt_r     <= '0;
      t_cnt_r     <= '0;
      load_row_r  <= '0;
      load_col_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we && (cfg_index == mpsq_pkg::CFG_MATRIX_SIZE)) begin
        size_r     <= cfg_data[mpsq_pkg::SIZE_W-1:0];
        // a size write restarts the load
        load_row_r <= '0;
        load_col_r <= '0;
      end else if (in_xfer) begin
        if (load_col_r == dim_m1) begin
          load_col_r <= '0;
          load_row_r <= load_done ? '0 : load_row_r + IDX_W'(1);
        end else begin
          load_col_r <= load_col_r + IDX_W'(1);
        end
      end
      if (cfg_we && (cfg_index == mpsq_pkg::CFG_EXPONENT)) begin
        exp_r <= cfg_data[mpsq_pkg::EXP_W-1:0];
      end

      case (state_r)
        mpsq_pkg::S_INIT: rem_r <= exp_r;
        mpsq_pkg::S_DECIDE: begin
          if (rem_r[0]) begin
            is_sq_r <= 1'b0;
          end else begin
            rem_r   <= rem_r >> 1;
            is_sq_r <= 1'b1;
          end
        end
        mpsq_pkg::S_WB: begin
          if (!is_sq_r) begin
            rem_r[0] <= 1'b0;
          end
        end
        default: ;
      endcase

      // row and step counters shared by product and output phases
      if ((state_r == mpsq_pkg::S_PREP) || (state_r == mpsq_pkg::S_OPREP)) begin
        r_cnt_r <= '0;
      end
      if ((state_r == mpsq_pkg::S_ROW) || (state_r == mpsq_pkg::S_OROW)) begin
        t_cnt_r <= '0;
      end
      if ((state_r == mpsq_pkg::S_MAC) || out_fill) begin
        if (t_end) begin
          r_cnt_r <= r_cnt_r + IDX_W'(1);
        end else begin
          t_cnt_r <= t_cnt_r + IDX_W'(1);
        end
      end

      if (out_fill) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (out_fill) begin
      out_data_r <= a_bcast;
      out_last_r <= r_end && t_end;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_element_out    = out_data_r;
  assign out_last_of_matrix = out_last_r;

  // chain of column cells; the row tap of cell 0 is broadcast as the a operand
  assign row_chain[MAX_DIM] = '0;
  assign a_bcast            = row_chain[0];

  for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
    mpsq_cell #(
      .MAX_DIM  (MAX_DIM),
      .CELL_IDX (g)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .dim_m1    (dim_m1),
      .load_row  (load_row_r),
      .load_col  (load_col_r),
      .load_data (in_element_in),
      .a_bcast   (a_bcast),
      .row_in    (row_chain[g+1]),
      .row_out   (row_chain[g])
    );
  end

`ifndef NO_ASSERTIONS
  // results only appear from the output phase
  a_out_from_oshift: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == mpsq_pkg::S_OSHIFT))
    else $error("result transfer outside output phase");

  // the final element closes the matrix and returns to loading
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fill && r_end && t_end) |=> (state_r == mpsq_pkg::S_IDLE))
    else $error("last element not followed by idle");

  // a multiply write-back only happens for a set exponent bit
  a_mul_bit_set: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mpsq_pkg::S_WB && !is_sq_r) |-> rem_r[0])
    else $error("multiply without exponent bit");
`endif

endmodule

@@ hw/rtl/mpsq_cell.sv @@
`timescale 1ns / 1ps
// one column cell: base, product and operand columns, row tap and mac
// depends on mpsq_pkg

module mpsq_cell #(
  parameter int MAX_DIM  = mpsq_pkg::MAX_DIM_DEF,
  parameter int CELL_IDX = 0,
  localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input  logic                        clk,
  input  mpsq_pkg::cell_ctl_t         ctl,
  input  logic [IDX_W-1:0]            dim_m1,
  input  logic [IDX_W-1:0]            load_row,
  input  logic [IDX_W-1:0]            load_col,
  input  logic [mpsq_pkg::ELEM_W-1:0] load_data,
  input  logic [mpsq_pkg::ELEM_W-1:0] a_bcast,
  input  logic [mpsq_pkg::ELEM_W-1:0] row_in,
  output logic [mpsq_pkg::ELEM_W-1:0] row_out
);

  logic [mpsq_pkg::ELEM_W-1:0] base_r [MAX_DIM];
  logic [mpsq_pkg::ELEM_W-1:0] prod_r [MAX_DIM];
  logic [mpsq_pkg::ELEM_W-1:0] aop_r  [MAX_DIM];
  logic [mpsq_pkg::ELEM_W-1:0] base_rot [MAX_DIM];
  logic [mpsq_pkg::ELEM_W-1:0] aop_rot  [MAX_DIM];
  logic [mpsq_pkg::ELEM_W-1:0] row_r;
  logic [mpsq_pkg::ELEM_W-1:0] acc_r;
  logic [mpsq_pkg::ELEM_W-1:0] mul_w;
  logic [mpsq_pkg::ELEM_W-1:0] sum_w;
  logic                        load_hit;

  assign mul_w    = a_bcast * base_r[0];
  assign sum_w    = acc_r + mul_w;
  assign row_out  = row_r;
  assign load_hit = ctl.load_en && (load_col == IDX_W'(CELL_IDX));

  // rotate up within the active n entries; base wraps at n-1, the operand column takes the sum there
  always_comb begin
    for (int i = 0; i < MAX_DIM; i++) begin
      if (dim_m1 == IDX_W'(i)) begin
        base_rot[i] = base_r[0];
        aop_rot[i]  = sum_w;
      end else if (i < MAX_DIM - 1) begin
        base_rot[i] = base_r[(i + 1) % MAX_DIM];
        aop_rot[i]  = aop_r[(i + 1) % MAX_DIM];
      end else begin
        base_rot[i] = base_r[i];
        aop_rot[i]  = aop_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_hit) begin
      base_r[load_row] <= load_data;
    end else if (ctl.base_wr) begin
      base_r <= aop_r;
    end else if (ctl.mac_en) begin
      base_r <= base_rot;
    end

    if (ctl.prod_ident) begin
      for (int i = 0; i < MAX_DIM; i++) begin
        prod_r[i] <= (i == CELL_IDX) ? 32'd1 : 32'd0;
      end
    end else if (ctl.prod_wr) begin
      prod_r <= aop_r;
    end

    if (ctl.aop_from_p) begin
      aop_r <= prod_r;
    end else if (ctl.aop_from_b) begin
      aop_r <= base_r;
    end else if (ctl.aop_rot) begin
      aop_r <= aop_rot;
    end

    if (ctl.row_load) begin
      row_r <= aop_r[0];
    end else if (ctl.row_shift) begin
      row_r <= row_in;
    end

    if (ctl.acc_clr) begin
      acc_r <= '0;
    end else if (ctl.mac_en) begin
      acc_r <= sum_w;
    end
  end

endmodule

@@ verif/matrix_power_by_squaring_unit_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for matrix_power_by_squaring_unit
// depends on mpsq_pkg and the unit rtl; all stimulus and prediction are built in

module matrix_power_by_squaring_unit_tb;

  localparam int DIM = mpsq_pkg::MAX_DIM_DEF;
  localparam int IDLE_LIMIT = 40000;  // longest product chain plus stalls, several times over
  localparam int SETTLE_CYCLES = 20;
  // no register behind these
  localparam logic [mpsq_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [mpsq_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam bit MUL_INTO_PRODUCT = 1'b0;
  localparam bit SQUARE_BASE = 1'b1;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [mpsq_pkg::ELEM_W-1:0] in_element_in;
  logic out_valid;
  logic out_stall;
  logic signed [mpsq_pkg::ELEM_W-1:0] out_element_out;
  logic out_last_of_matrix;
  logic cfg_we;
  logic [mpsq_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mpsq_pkg::CFG_DATA_W-1:0] cfg_data;

  matrix_power_by_squaring_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_element_in(in_element_in),
    .out_valid(out_valid), .out_stall(out_stall), .out_element_out(out_element_out),
    .out_last_of_matrix(out_last_of_matrix),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // pending input elements and expected result elements
  logic [mpsq_pkg::ELEM_W-1:0] element_q[$];
  logic [mpsq_pkg::ELEM_W-1:0] power_elem_q[$];
  bit power_last_q[$];

  // predictor state
  logic [mpsq_pkg::SIZE_W-1:0] size_reg;
  logic [mpsq_pkg::EXP_W-1:0] exp_reg;
  logic [mpsq_pkg::ELEM_W-1:0] base_m[DIM*DIM];
  logic [mpsq_pkg::ELEM_W-1:0] prod_m[DIM*DIM];
  logic [mpsq_pkg::ELEM_W-1:0] tmp_m[DIM*DIM];
  int load_cnt;

  int errors;
  int sent;
  bit no_idle;
  bit in_took;
  int in_gap;
  int out_hold;
  int idle_cycles;

  function automatic int eff_dim(logic [mpsq_pkg::SIZE_W-1:0] s);
    if (s == 0) return 1;
    if (s > DIM) return DIM;
    return int'(s);
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (no_idle || p < 60) return 0;
    if (p < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one matrix product: product = product * base, or base = base * base
  task automatic multiply_into(bit square, int n);
    logic [mpsq_pkg::ELEM_W-1:0] acc;
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        acc = '0;
        for (int t = 0; t < n; t++) begin
          if (square) acc += base_m[r*DIM+t] * base_m[t*DIM+c];
          else acc += prod_m[r*DIM+t] * base_m[t*DIM+c];
        end
        tmp_m[r*DIM+c] = acc;
      end
    end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        if (square) base_m[i*DIM+j] = tmp_m[i*DIM+j];
        else prod_m[i*DIM+j] = tmp_m[i*DIM+j];
  endtask

  // take one element; on the last one of the matrix, raise it to the power
  task automatic absorb_element(logic [mpsq_pkg::ELEM_W-1:0] v);
    int n;
    int total;
    logic [mpsq_pkg::EXP_W-1:0] e;
    n = eff_dim(size_reg);
    total = n * n;
    if (load_cnt >= total) load_cnt = 0;
    base_m[(load_cnt / n)*DIM + (load_cnt % n)] = v;
    load_cnt++;
    if (load_cnt < total) return;
    load_cnt = 0;
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        prod_m[r*DIM+c] = (r == c) ? 32'd1 : 32'd0;
    e = exp_reg;
    while (e != 0) begin
      if (e[0]) multiply_into(MUL_INTO_PRODUCT, n);
      e = e >> 1;
      if (e != 0) multiply_into(SQUARE_BASE, n);
    end
    for (int k = 0; k < total; k++) begin
      power_elem_q.push_back(prod_m[(k / n)*DIM + (k % n)]);
      power_last_q.push_back(k + 1 == total);
    end
  endtask

  // input driver: new values at the falling edge, a stalled transfer holds
  always @(negedge clk) begin
    if (rst_n) begin
      if (!(in_valid && !in_took)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (element_q.size() > 0) begin
          in_valid <= 1'b1;
          in_element_in <= element_q[0];
          in_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side backpressure
  always @(negedge clk) begin
    if (rst_n) begin
      out_stall <= (out_hold > 0);
      if (out_hold > 0) out_hold--;
      else out_hold = pick_gap();
    end
  end

  // monitor: accepted transfers on both channels, plus the no-progress watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      in_took = in_valid && !in_stall;
      if (in_took) absorb_element(element_q.pop_front());
      if (out_valid && !out_stall) begin
        if (power_elem_q.size() == 0) begin
          $display("%0t: unexpected result element %h last %b", $time,
                   out_element_out, out_last_of_matrix);
          errors++;
        end else begin
          if (out_element_out !== power_elem_q[0]) begin
            $display("%0t: element expected %h actual %h", $time,
                     power_elem_q[0], out_element_out);
            errors++;
          end
          if (out_last_of_matrix !== power_last_q[0]) begin
            $display("%0t: last flag expected %b actual %b", $time,
                     power_last_q[0], out_last_of_matrix);
            errors++;
          end
          void'(power_elem_q.pop_front());
          void'(power_last_q.pop_front());
        end
      end
      if (in_took || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("matrix_power_by_squaring_unit_tb: FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [mpsq_pkg::CFG_IDX_W-1:0] idx,
                           logic [mpsq_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == mpsq_pkg::CFG_MATRIX_SIZE) begin
      size_reg = val[mpsq_pkg::SIZE_W-1:0];
      load_cnt = 0;
    end else if (idx == mpsq_pkg::CFG_EXPONENT) begin
      exp_reg = val[mpsq_pkg::EXP_W-1:0];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send(logic [mpsq_pkg::ELEM_W-1:0] v);
    element_q.push_back(v);
    sent++;
  endtask

  // wait until every element is taken and every result has come out
  task automatic drain();
    wait (element_q.size() == 0 && !in_valid && power_elem_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [mpsq_pkg::ELEM_W-1:0] rand_elem();
    int p;
    p = $urandom_range(99);
    if (p < 45) return $urandom();
    if (p < 85) return $urandom_range(6) - 3;
    if (p < 92) return 32'h7fffffff;
    return 32'h80000000;
  endfunction

  function automatic logic [mpsq_pkg::EXP_W-1:0] rand_exp();
    int p;
    p = $urandom_range(99);
    if (p < 15) return '0;
    if (p < 30) return mpsq_pkg::EXP_W'(1);
    if (p < 70) return mpsq_pkg::EXP_W'($urandom_range(2, 20));
    if (p < 90) return mpsq_pkg::EXP_W'($urandom() >> 1);
    return 31'h7fffffff;
  endfunction

  function automatic logic [mpsq_pkg::SIZE_W-1:0] rand_size();
    int p;
    p = $urandom_range(99);
    if (p < 80) return mpsq_pkg::SIZE_W'($urandom_range(0, 4));
    if (p < 93) return mpsq_pkg::SIZE_W'($urandom_range(5, 7));
    return mpsq_pkg::SIZE_W'($urandom_range(8, 15));
  endfunction

  initial begin
    int n;
    int mats;
    errors = 0;
    sent = 0;
    no_idle = 1'b0;
    in_took = 1'b0;
    in_gap = 0;
    out_hold = 0;
    idle_cycles = 0;
    in_valid = 1'b0;
    in_element_in = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = mpsq_pkg::CFG_MATRIX_SIZE;
    cfg_data = '0;
    size_reg = mpsq_pkg::SIZE_RESET;
    exp_reg = mpsq_pkg::EXP_RESET;
    load_cnt = 0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: 1x1, power one, field extremes
    send(32'h7fffffff);
    send(32'h80000000);
    send(32'hffffffff);
    send(32'h0);
    drain();

    // power zero gives the identity
    write_reg(mpsq_pkg::CFG_MATRIX_SIZE, 31'd2);
    write_reg(mpsq_pkg::CFG_EXPONENT, 31'd0);
    repeat (4) send(rand_elem());
    drain();

    // size zero acts as one, squared
    write_reg(mpsq_pkg::CFG_MATRIX_SIZE, 31'd0);
    write_reg(mpsq_pkg::CFG_EXPONENT, 31'd2);
    send(32'h0001_0001);
    send(32'hffff_ffff);
    drain();

    // spare register indexes do nothing
    write_reg(CFG_SPARE_A, 31'h7fffffff);
    write_reg(CFG_SPARE_B, 31'h55555555);

    // largest exponent on a 3x3
    write_reg(mpsq_pkg::CFG_MATRIX_SIZE, 31'h7ffffff3);
    write_reg(mpsq_pkg::CFG_EXPONENT, 31'h7fffffff);
    repeat (9) send(rand_elem());
    drain();

    // exponent changed mid-load takes effect, size rewrite restarts the load
    write_reg(mpsq_pkg::CFG_MATRIX_SIZE, 31'd2);
    send(32'd3);
    send(32'd5);
    drain();
    write_reg(mpsq_pkg::CFG_EXPONENT, 31'd5);
    send(32'd7);
    drain();
    write_reg(mpsq_pkg::CFG_MATRIX_SIZE, 31'd2);
    repeat (4) send(rand_elem());
    drain();

    // oversized size register clamps to the full 8x8
    write_reg(mpsq_pkg::CFG_MATRIX_SIZE, 31'd15);
    write_reg(mpsq_pkg::CFG_EXPONENT, 31'd3);
    repeat (DIM*DIM) send(rand_elem());
    drain();

    // random phases: mostly clean matrices, occasional broken loads
    while (sent < 360) begin
      no_idle = ($urandom_range(4) == 0);
      write_reg(mpsq_pkg::CFG_EXPONENT, rand_exp());
      write_reg(mpsq_pkg::CFG_MATRIX_SIZE, (31'($urandom()) & ~31'hf) | 31'(rand_size()));
      n = eff_dim(size_reg);
      if ($urandom_range(9) == 0 && n > 1) begin
        repeat ($urandom_range(1, n*n - 1)) send(rand_elem());
        drain();
        if ($urandom_range(1)) write_reg(mpsq_pkg::CFG_EXPONENT, rand_exp());
        write_reg(mpsq_pkg::CFG_MATRIX_SIZE, 31'(size_reg));
      end
      mats = $urandom_range(1, 3);
      repeat (mats) repeat (n*n) send(rand_elem());
      drain();
    end

    if (errors == 0) begin
      $display("matrix_power_by_squaring_unit_tb: PASS");
    end else begin
      $display("matrix_power_by_squaring_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
